### sv/rld_pkg.sv
`timescale 1ns / 1ps

package rld_pkg;

    // Default edge length of the cubic chunk, in cells.
    localparam int CHUNK_EDGE_DEFAULT = 32;

    // Width of the material count register and its value after reset.
    localparam int MAT_COUNT_W = 9;
    localparam logic [MAT_COUNT_W-1:0] MAT_COUNT_RESET = 9'd256;

    // Result codes reported with every result item.
    typedef enum logic [2:0] {
        OUT_IN_PROGRESS  = 3'd0,
        OUT_COMPLETE     = 3'd1,
        OUT_ZERO_RUN     = 3'd2,
        OUT_BAD_MATERIAL = 3'd3,
        OUT_OVERFLOW     = 3'd4,
        OUT_TRUNCATED    = 3'd5
    } t_outcome;

    // One payload byte with its framing flags.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       chunk_start;
        logic       message_end;
    } t_in_item;

    // One decoded run or status report.
    typedef struct packed {
        logic [7:0]  run_material;
        logic [14:0] run_start;
        logic [15:0] run_length;
        logic        run_valid;
        t_outcome    outcome;
    } t_out_item;

endpackage

### sv/voxel_run_length_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_item  (rld_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_item (rld_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (material count, 9 bits)
//
// One byte is accepted per cycle unless a stalled output holds a byte in the input register.
// The latency is set by the input register and the output register around the decode logic.
// Synchronous active-low reset returns the decoder to idle and the material count to 256.
// A stalled output holds a byte in the input register only when that byte has a result.
// The configuration port is always ready.

module voxel_run_length_decoder_top #(
    parameter int CHUNK_EDGE = rld_pkg::CHUNK_EDGE_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rld_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rld_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rld_pkg::MAT_COUNT_W-1:0]  i_cfg_data
);

    logic                            r_in_valid;
    rld_pkg::t_in_item               r_in_item;
    logic                            r_out_valid;
    rld_pkg::t_out_item              r_out_item;
    logic [rld_pkg::MAT_COUNT_W-1:0] r_material_count;

    logic               s_out_free;
    logic               s_step;
    logic               s_has_result;
    rld_pkg::t_out_item s_result;

    // The held byte moves on unless its result finds the output full.
    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_step      = r_in_valid && (!s_has_result || s_out_free);
    assign o_in_ready  = !r_in_valid || s_step;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // Material count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_material_count <= rld_pkg::MAT_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_material_count <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Record decoder.
    rld_decode #(
        .CHUNK_EDGE(CHUNK_EDGE)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (s_step),
        .i_item          (r_in_item),
        .i_material_count(r_material_count),
        .o_has_result    (s_has_result),
        .o_result        (s_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step && s_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step && s_has_result) begin
            r_out_item <= s_result;
        end
    end

`ifndef SYNTHESIS
    // An accepted run always covers at least one cell.
    a_valid_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.run_valid) |-> (o_out_item.run_length != 16'd0))
        else $error("accepted run with zero length");

    // A rejected or truncated report carries no length.
    a_reject_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.run_valid) |-> (o_out_item.run_length == 16'd0))
        else $error("rejected report with nonzero length");

    // Accepted runs never carry an error code.
    a_valid_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.run_valid) |->
            (o_out_item.outcome == rld_pkg::OUT_IN_PROGRESS ||
             o_out_item.outcome == rld_pkg::OUT_COMPLETE ||
             o_out_item.outcome == rld_pkg::OUT_TRUNCATED))
        else $error("accepted run with error code");

    // A byte held in the input register is neither lost nor changed.
    a_hold_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_step) |=> (r_in_valid && $stable(r_in_item)))
        else $error("stalled input byte lost");
`endif

endmodule

### sv/rld_decode.sv
`timescale 1ns / 1ps

module rld_decode #(
    parameter int CHUNK_EDGE = rld_pkg::CHUNK_EDGE_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  rld_pkg::t_in_item                i_item,
    input  logic [rld_pkg::MAT_COUNT_W-1:0]  i_material_count,
    output logic                             o_has_result,
    output rld_pkg::t_out_item               o_result
);

    localparam int CELL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int CW = $clog2(CELL_COUNT + 1);
    localparam logic [CW-1:0] CELLS = CW'(CELL_COUNT);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACTIVE,
        PH_DONE
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [2:0]    r_idx, n_idx;
    logic [7:0]    r_held, n_held;
    logic [31:0]   r_acc, n_acc;
    logic [CW-1:0] r_cells, n_cells;

    logic          s_active;
    logic [2:0]    s_idx;
    logic [7:0]    s_held;
    logic [31:0]   s_acc;
    logic [31:0]   s_run;
    logic [CW-1:0] s_cells;
    logic [CW-1:0] s_remaining;
    logic [31:0]   s_cells_ext;
    logic          s_rec_end;
    logic          s_zero;
    logic          s_bad;
    logic          s_over;
    logic          s_full;

    // A chunk start restarts decoding from a clean record.
    assign s_active    = i_item.chunk_start || (r_phase == PH_ACTIVE);
    assign s_idx       = i_item.chunk_start ? 3'd0 : r_idx;
    assign s_held      = i_item.chunk_start ? 8'd0 : r_held;
    assign s_acc       = i_item.chunk_start ? 32'd0 : r_acc;
    assign s_cells     = i_item.chunk_start ? '0 : r_cells;
    assign s_cells_ext = 32'(s_cells);

    // Place the byte into its lane of the little-endian run length.
    always_comb begin
        s_run = s_acc;
        case (s_idx)
            3'd1: s_run[7:0]   = i_item.payload_byte;
            3'd2: s_run[15:8]  = i_item.payload_byte;
            3'd3: s_run[23:16] = i_item.payload_byte;
            3'd4: s_run[31:24] = i_item.payload_byte;
            default: s_run = 32'd0;
        endcase
    end

    // Record checks against the cells still free in the chunk.
    assign s_rec_end   = (s_idx == 3'd4);
    assign s_remaining = CELLS - s_cells;
    assign s_zero      = (s_run == 32'd0);
    assign s_bad       = ({1'b0, s_held} >= i_material_count);
    assign s_over      = (s_run > 32'(s_remaining));
    assign s_full      = (s_run == 32'(s_remaining));

    // Next state and the result of the current byte.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_held  = r_held;
        n_acc   = r_acc;
        n_cells = r_cells;

        o_has_result          = 1'b0;
        o_result.run_material = s_held;
        o_result.run_start    = s_cells_ext[14:0];
        o_result.run_length   = 16'd0;
        o_result.run_valid    = 1'b0;
        o_result.outcome      = rld_pkg::OUT_IN_PROGRESS;

        if (s_active) begin
            n_phase = PH_ACTIVE;
            n_cells = s_cells;
            n_held  = (s_idx == 3'd0) ? i_item.payload_byte : s_held;
            n_acc   = s_run;
            n_idx   = s_idx + 3'd1;

            if (s_rec_end) begin
                n_idx        = 3'd0;
                o_has_result = 1'b1;
                if (s_zero) begin
                    n_phase          = PH_DONE;
                    o_result.outcome = rld_pkg::OUT_ZERO_RUN;
                end else if (s_bad) begin
                    n_phase          = PH_DONE;
                    o_result.outcome = rld_pkg::OUT_BAD_MATERIAL;
                end else if (s_over) begin
                    n_phase          = PH_DONE;
                    o_result.outcome = rld_pkg::OUT_OVERFLOW;
                end else begin
                    n_cells             = s_cells + s_run[CW-1:0];
                    o_result.run_length = s_run[15:0];
                    o_result.run_valid  = 1'b1;
                    if (s_full) begin
                        n_phase          = PH_DONE;
                        o_result.outcome = rld_pkg::OUT_COMPLETE;
                    end else if (i_item.message_end) begin
                        n_phase          = PH_DONE;
                        o_result.outcome = rld_pkg::OUT_TRUNCATED;
                    end
                end
            end else if (i_item.message_end) begin
                // The message ended inside a record.
                n_phase               = PH_DONE;
                n_idx                 = 3'd0;
                o_has_result          = 1'b1;
                o_result.run_material = 8'd0;
                o_result.outcome      = rld_pkg::OUT_TRUNCATED;
            end
        end
    end

    // Decoder state advances only when the byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= 3'd0;
            r_held  <= 8'd0;
            r_acc   <= 32'd0;
            r_cells <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_held  <= n_held;
            r_acc   <= n_acc;
            r_cells <= n_cells;
        end
    end

`ifndef SYNTHESIS
    // The byte position never passes the last byte of a record.
    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd4)
        else $error("record byte index out of range");

    // The covered cell count never passes the chunk size.
    a_cells_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cells <= CELLS)
        else $error("covered cells exceed chunk size");

    // Outside decoding no partial record is held.
    a_idle_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_ACTIVE) |-> (r_idx == 3'd0))
        else $error("partial record held outside decoding");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int EDGE = rld_pkg::CHUNK_EDGE_DEFAULT;
    localparam int CELLS = EDGE * EDGE * EDGE;
    localparam rld_pkg::t_out_item NO_RUN = '0;

    // Decoder progress as tracked by the scoreboard.
    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_ACTIVE,
        DEC_DONE
    } t_dec_state;

    // One line of the directed table: a payload item or a material count write.
    typedef struct {
        bit                              is_cfg;
        logic [rld_pkg::MAT_COUNT_W-1:0] cfg_value;
        rld_pkg::t_in_item               item;
        bit                              has_typed;
        rld_pkg::t_out_item              typed;
    } t_table_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    rld_pkg::t_in_item               i_in_item;
    logic                            o_out_valid;
    logic                            i_out_ready;
    rld_pkg::t_out_item              o_out_item;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [rld_pkg::MAT_COUNT_W-1:0] i_cfg_data;

    // Scoreboard copy of the decoder state and its register.
    logic [rld_pkg::MAT_COUNT_W-1:0] material_limit;
    t_dec_state                      dec_state;
    int                              rec_pos;
    logic [7:0]                      cur_material;
    logic [31:0]                     run_acc;
    int                              cells_done;

    rld_pkg::t_out_item              pending_runs[$];
    t_table_row                      directed_rows[$];
    bit                              typed_on;
    rld_pkg::t_out_item              typed_result;
    int                              error_count;
    int                              send_idle_pct;
    int                              recv_stall_pct;
    int                              chunk_bytes_fed;

    voxel_run_length_decoder_top #(
        .CHUNK_EDGE(EDGE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the decoder hangs.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Build the result item the decoder should report.
    function automatic rld_pkg::t_out_item run_item(input logic [7:0] mat,
                                                    input logic [14:0] first,
                                                    input logic [15:0] len, input logic ok,
                                                    input rld_pkg::t_outcome oc);
        rld_pkg::t_out_item r;
        r.run_material = mat;
        r.run_start = first;
        r.run_length = len;
        r.run_valid = ok;
        r.outcome = oc;
        return r;
    endfunction

    // Decode one accepted payload byte; has is set when it ends a record or the message.
    task automatic decode_payload_byte(input rld_pkg::t_in_item it, output bit has,
                                       output rld_pkg::t_out_item r);
        has = 1'b0;
        r = NO_RUN;
        if (it.chunk_start) begin
            dec_state = DEC_ACTIVE;
            rec_pos = 0;
            cur_material = '0;
            run_acc = '0;
            cells_done = 0;
        end
        if (dec_state == DEC_ACTIVE) begin
            if (rec_pos == 0) begin
                cur_material = it.payload_byte;
                run_acc = '0;
            end else begin
                run_acc = run_acc | (32'(it.payload_byte) << (8 * (rec_pos - 1)));
            end
            rec_pos++;
            if (rec_pos == 5) begin
                // Whole record in hand: check errors in order, then account the run.
                rec_pos = 0;
                has = 1'b1;
                r.run_material = cur_material;
                r.run_start = cells_done[14:0];
                if (run_acc == 0) begin
                    dec_state = DEC_DONE;
                    r.outcome = rld_pkg::OUT_ZERO_RUN;
                end else if (cur_material >= material_limit) begin
                    dec_state = DEC_DONE;
                    r.outcome = rld_pkg::OUT_BAD_MATERIAL;
                end else if (longint'(cells_done) + longint'(run_acc) > longint'(CELLS)) begin
                    dec_state = DEC_DONE;
                    r.outcome = rld_pkg::OUT_OVERFLOW;
                end else begin
                    cells_done = cells_done + int'(run_acc);
                    r.run_length = run_acc[15:0];
                    r.run_valid = 1'b1;
                    if (cells_done == CELLS) begin
                        dec_state = DEC_DONE;
                        r.outcome = rld_pkg::OUT_COMPLETE;
                    end else if (it.message_end) begin
                        dec_state = DEC_DONE;
                        r.outcome = rld_pkg::OUT_TRUNCATED;
                    end else begin
                        r.outcome = rld_pkg::OUT_IN_PROGRESS;
                    end
                end
            end else if (it.message_end) begin
                // Message ran out inside a record.
                dec_state = DEC_DONE;
                rec_pos = 0;
                has = 1'b1;
                r.run_start = cells_done[14:0];
                r.outcome = rld_pkg::OUT_TRUNCATED;
            end
        end
    endtask

    // Check results, track register writes and predict on every accepted item.
    always @(posedge i_clk) begin : scoreboard
        rld_pkg::t_out_item want;
        rld_pkg::t_out_item got;
        bit has;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                if (pending_runs.size() == 0) begin
                    $display("%0t: result with nothing expected:", $time,
                             " mat %0d start %0d len %0d", got.run_material, got.run_start,
                             got.run_length, " valid %0d outcome %0d", got.run_valid,
                             got.outcome);
                    error_count++;
                end else begin
                    want = pending_runs.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected", $time,
                                 " mat %0d start %0d len %0d", want.run_material,
                                 want.run_start, want.run_length,
                                 " valid %0d outcome %0d", want.run_valid, want.outcome);
                        $display("%0t:          actual  ", $time,
                                 " mat %0d start %0d len %0d", got.run_material,
                                 got.run_start, got.run_length,
                                 " valid %0d outcome %0d", got.run_valid, got.outcome);
                        error_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                material_limit = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                decode_payload_byte(i_in_item, has, want);
                if (typed_on) begin
                    pending_runs.insert(pending_runs.size(), typed_result);
                end else if (has) begin
                    pending_runs.insert(pending_runs.size(), want);
                end
            end
        end
    end

    // Output stalls, redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present one item, with optional idle cycles first, and wait until it is taken.
    task automatic send_byte(input rld_pkg::t_in_item item, input bit typed,
                             input rld_pkg::t_out_item r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_on = typed;
        typed_result = r;
        i_in_valid <= 1'b1;
        i_in_item <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop feeding and let every outstanding result and in-flight byte drain.
    task automatic settle_decoder();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_material_count(input logic [rld_pkg::MAT_COUNT_W-1:0] value);
        settle_decoder();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input logic [7:0] b, input bit s, input bit e,
                                    input bit typed, input rld_pkg::t_out_item r);
        t_table_row row;
        row.is_cfg = 1'b0;
        row.cfg_value = '0;
        row.item = {b, s, e};
        row.has_typed = typed;
        row.typed = r;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_cfg(input logic [rld_pkg::MAT_COUNT_W-1:0] value);
        t_table_row row;
        row.is_cfg = 1'b1;
        row.cfg_value = value;
        row.item = '0;
        row.has_typed = 1'b0;
        row.typed = NO_RUN;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // One chunk of mostly well-formed records with random content, sometimes broken
    // by an early message end or an abandoned record, followed by up to two stray bytes.
    task automatic feed_chunk();
        longint left;
        int nrec;
        int kind;
        int cut;
        int drop;
        int pos;
        bit tail_end;
        bit stop;
        bit e;
        logic [7:0] mat;
        logic [31:0] len;
        logic [39:0] rec_bytes;
        left = CELLS;
        nrec = $urandom_range(1, 6);
        cut = ($urandom_range(99) < 15) ? $urandom_range(0, nrec * 5 - 1) : -1;
        drop = ($urandom_range(99) < 6) ? $urandom_range(0, nrec * 5 - 1) : -1;
        tail_end = $urandom_range(1);
        pos = 0;
        stop = 1'b0;
        for (int r = 0; r < nrec && !stop; r++) begin
            kind = $urandom_range(99);
            mat = $urandom_range(0, material_limit - 1);
            if (kind < 8) begin
                len = '0;
            end else if (kind < 16 && material_limit < 256) begin
                mat = $urandom_range(material_limit, 255);
                len = $urandom_range(1, 100);
            end else if (kind < 22) begin
                len = ($urandom_range(1) == 1) ? $urandom : 32'(left) + $urandom_range(1, 40);
            end else if (kind < 35) begin
                len = 32'(left);
            end else if (kind < 50) begin
                len = $urandom_range(1, (left < 4000) ? left : 4000);
            end else begin
                len = $urandom_range(1, (left < 64) ? left : 64);
            end
            rec_bytes = {len, mat};
            for (int b = 0; b < 5 && !stop; b++) begin
                e = (pos == cut) || (tail_end && r == nrec - 1 && b == 4);
                send_byte({rec_bytes[8 * b +: 8], pos == 0, e}, 1'b0, NO_RUN);
                chunk_bytes_fed++;
                if (pos == cut || pos == drop) stop = 1'b1;
                pos++;
            end
            // A rejected record or a full chunk ends it.
            if (len == 0 || mat >= material_limit || longint'(len) >= left) begin
                stop = 1'b1;
            end else begin
                left = left - longint'(len);
            end
        end
        repeat ($urandom_range(0, 2)) begin
            send_byte({8'($urandom), 1'b0, 1'($urandom_range(1))}, 1'b0, NO_RUN);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        typed_on = 1'b0;
        typed_result = NO_RUN;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        chunk_bytes_fed = 0;
        material_limit = rld_pkg::MAT_COUNT_RESET;
        dec_state = DEC_IDLE;
        rec_pos = 0;
        cur_material = '0;
        run_acc = '0;
        cells_done = 0;

        // Largest material code with a one-cell run, at the reset material count.
        add_row(8'hFF, 1, 0, 0, NO_RUN);
        add_row(8'h01, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 1, run_item(8'hFF, 0, 1, 1, rld_pkg::OUT_IN_PROGRESS));
        // A run that is still accepted when the message ends before the chunk is full.
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h02, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 1, 1, run_item(8'h00, 1, 2, 1, rld_pkg::OUT_TRUNCATED));
        // After the chunk has finished, bytes are ignored.
        add_row(8'hAA, 0, 1, 0, NO_RUN);
        // The whole chunk in a single run.
        add_row(8'h07, 1, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h80, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 1, run_item(8'h07, 0, 16'h8000, 1, rld_pkg::OUT_COMPLETE));
        // Largest run length overflows the chunk.
        add_row(8'h01, 1, 0, 0, NO_RUN);
        add_row(8'hFF, 0, 0, 0, NO_RUN);
        add_row(8'hFF, 0, 0, 0, NO_RUN);
        add_row(8'hFF, 0, 0, 0, NO_RUN);
        add_row(8'hFF, 0, 0, 1, run_item(8'h01, 0, 0, 0, rld_pkg::OUT_OVERFLOW));
        // A new chunk start drops a partial record; the message then ends inside a record.
        add_row(8'h03, 1, 0, 0, NO_RUN);
        add_row(8'h12, 0, 0, 0, NO_RUN);
        add_row(8'h04, 1, 1, 1, run_item(8'h00, 0, 0, 0, rld_pkg::OUT_TRUNCATED));
        // Material count of one: a zero run is reported ahead of a bad material.
        add_cfg(9'd1);
        add_row(8'h01, 1, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 1, run_item(8'h01, 0, 0, 0, rld_pkg::OUT_ZERO_RUN));
        add_row(8'h01, 1, 0, 0, NO_RUN);
        add_row(8'h05, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 0, NO_RUN);
        add_row(8'h00, 0, 0, 1, run_item(8'h01, 0, 0, 0, rld_pkg::OUT_BAD_MATERIAL));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_material_count(directed_rows[i].cfg_value);
            end else begin
                send_byte(directed_rows[i].item, directed_rows[i].has_typed,
                          directed_rows[i].typed);
            end
        end

        // Random chunks under four idling patterns, each with its own material count.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_material_count(9'd256);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_material_count(9'd1);
                    send_idle_pct = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_material_count(9'($urandom_range(2, 255)));
                    send_idle_pct = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    write_material_count(9'($urandom_range(1, 256)));
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            chunk_bytes_fed = 0;
            while (chunk_bytes_fed < 140) feed_chunk();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
sv/rld_pkg.sv
sv/rld_decode.sv
sv/voxel_run_length_decoder_top.sv
test/testbench.sv
